// ===== hdl/pdi_pkg.sv =====
// shared types and constants of the parking distance indicator
// request and result payloads, config register codes, control structs
// no dependencies
`default_nettype none

package pdi_pkg;

    localparam int DIST_W  = 12;
    localparam int TIME_W  = 32;
    localparam int INTV_W  = 16;
    localparam int LEVEL_W = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    // numerator 255*d needs 8 more bits than a distance
    localparam int NUM_W = DIST_W + LEVEL_W;
    localparam int QCNT_W = $clog2(LEVEL_W);

    localparam logic [LEVEL_W-1:0] FULL_LEVEL = 8'd255;

    // config register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FAR    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIDDLE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NEAR   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CLOSE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_INTV   = 3'd4;

    // config reset values
    localparam logic [DIST_W-1:0] RST_FAR    = 12'd1000;
    localparam logic [DIST_W-1:0] RST_MIDDLE = 12'd500;
    localparam logic [DIST_W-1:0] RST_NEAR   = 12'd100;
    localparam logic [DIST_W-1:0] RST_CLOSE  = 12'd300;
    localparam logic [INTV_W-1:0] RST_INTV   = 16'd1000;

    // stop / force-close status codes
    localparam logic [1:0] ST_NONE   = 2'd0;
    localparam logic [1:0] ST_ACCEPT = 2'd1;
    localparam logic [1:0] ST_REJECT = 2'd2;

    typedef struct packed {
        logic [DIST_W-1:0] distance_mm;
        logic [TIME_W-1:0] now_ms;
        logic              assist_request;
        logic              stop_request;
        logic              force_close;
        logic              touch_pressed;
    } t_in;

    typedef struct packed {
        logic               running;
        logic               led_one_on;
        logic               led_two_on;
        logic [LEVEL_W-1:0] level_one;
        logic [LEVEL_W-1:0] level_two;
        logic [1:0]         stop_status;
        logic [1:0]         force_status;
        logic               release_assist;
        logic               distance_notice;
        logic               touching_notice;
        logic               can_stop_notice;
    } t_out;

    typedef struct packed {
        logic load_in;
        logic start_div;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic div_done;
    } t_sts;

endpackage

`default_nettype wire

// ===== hdl/pdi_div.sv =====
// serial restoring divider, one quotient bit per cycle
// computes 255*a/b for an 8-bit quotient (caller guarantees a <= b)
// depends on pdi_pkg
`default_nettype none

module pdi_div (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_start,
    input  wire  [pdi_pkg::DIST_W-1:0]   i_num,
    input  wire  [pdi_pkg::DIST_W-1:0]   i_den,
    output logic                         o_done,
    output logic [pdi_pkg::LEVEL_W-1:0]  o_quot
);

    logic                          r_busy;
    logic [pdi_pkg::QCNT_W-1:0]    r_cnt;
    logic [pdi_pkg::NUM_W-1:0]     r_rem;
    logic [pdi_pkg::DIST_W-1:0]    r_den;
    logic [pdi_pkg::LEVEL_W-1:0]   r_quot;

    logic [pdi_pkg::NUM_W-1:0]     num_ext;
    logic [pdi_pkg::NUM_W-1:0]     den_sh;
    logic                          fits;

    // 255*a as (a << 8) - a
    assign num_ext = (pdi_pkg::NUM_W'(i_num) << pdi_pkg::LEVEL_W) - pdi_pkg::NUM_W'(i_num);
    assign den_sh  = pdi_pkg::NUM_W'(r_den) << r_cnt;
    assign fits    = (r_rem >= den_sh);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= pdi_pkg::QCNT_W'(pdi_pkg::LEVEL_W - 1);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= num_ext;
            r_den  <= i_den;
            r_quot <= '0;
        end else if (r_busy) begin
            if (fits) begin
                r_rem <= r_rem - den_sh;
            end
            r_quot <= {r_quot[pdi_pkg::LEVEL_W-2:0], fits};
        end
    end

    // high during the last iteration; the quotient register takes its last bit at the end of it
    assign o_done = r_busy && (r_cnt == '0);
    assign o_quot = r_quot;

`ifndef NO_ASSERTIONS
    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy)
        else $error("divider restarted while busy");

    a_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && (r_cnt == '0) && !i_start) |=> !r_busy)
        else $error("divider did not stop after last bit");
`endif

endmodule

`default_nettype wire

// ===== hdl/pdi_ctrl.sv =====
// sequencer of the parking distance indicator: request intake, divide, result hand-off
// drives command struct to the datapath and owns the result valid flag
// depends on pdi_pkg
`default_nettype none

module pdi_ctrl (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_in_valid,
    output logic           o_in_stall,
    output logic           o_out_valid,
    input  wire            i_out_stall,
    input  pdi_pkg::t_sts  i_sts,
    output pdi_pkg::t_cmd  o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_CALC = 4'b0010,
        S_DIV  = 4'b0100,
        S_OUT  = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   accepted;
    logic   out_free;

    assign o_in_stall = (r_state != S_IDLE);
    assign accepted   = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_CALC;
                end
            end
            S_CALC: begin
                n_state = S_DIV;
            end
            S_DIV: begin
                if (i_sts.div_done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd.load_in   = accepted;
        o_cmd.start_div = (r_state == S_CALC);
        o_cmd.commit    = (r_state == S_OUT) && out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.commit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;

`ifndef NO_ASSERTIONS
    a_accept_calc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accepted |=> (r_state == S_CALC))
        else $error("accepted request did not start calculation");

    a_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_sts.div_done |-> (r_state == S_DIV))
        else $error("divider finished outside divide state");

    a_commit_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |=> o_out_valid)
        else $error("committed result not presented");
`endif

endmodule

`default_nettype wire

// ===== hdl/pdi_dp.sv =====
// datapath of the parking distance indicator: config registers, tick state,
// band decode, notice timers and result register; uses pdi_div for LED levels
// depends on pdi_pkg and pdi_div
`default_nettype none

module pdi_dp (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_cfg_we,
    input  wire  [pdi_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire  [pdi_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  pdi_pkg::t_in                     i_in,
    input  pdi_pkg::t_cmd                    i_cmd,
    output pdi_pkg::t_sts                    o_sts,
    output pdi_pkg::t_out                    o_out
);

    // config
    logic [pdi_pkg::DIST_W-1:0]  r_far, r_mid, r_near, r_close;
    logic [pdi_pkg::INTV_W-1:0]  r_intv;

    // tick state
    logic                         r_run, n_run;
    logic                         r_led1, n_led1;
    logic                         r_led2, n_led2;
    logic [pdi_pkg::LEVEL_W-1:0]  r_lvl1, n_lvl1;
    logic [pdi_pkg::LEVEL_W-1:0]  r_lvl2, n_lvl2;
    logic [pdi_pkg::TIME_W-1:0]   r_t_dist, n_t_dist;
    logic [pdi_pkg::TIME_W-1:0]   r_t_touch, n_t_touch;
    logic [pdi_pkg::TIME_W-1:0]   r_t_stop, n_t_stop;

    pdi_pkg::t_in                 r_in;
    pdi_pkg::t_out                r_out;
    pdi_pkg::t_out                n_out;

    logic [pdi_pkg::DIST_W-1:0]   d;
    logic [pdi_pkg::TIME_W-1:0]   now;
    logic [pdi_pkg::TIME_W-1:0]   intv_ext;
    logic                         band_one, band_two, beyond;
    logic                         in_close, near_hit;
    logic                         dist_due, touch_due, stop_due;
    logic [pdi_pkg::DIST_W-1:0]   div_a, div_b;
    logic                         div_done;
    logic [pdi_pkg::LEVEL_W-1:0]  quot;
    logic [1:0]                   stop_st, force_st;
    logic                         rel, dn, tn, cn;

    assign d        = r_in.distance_mm;
    assign now      = r_in.now_ms;
    assign intv_ext = pdi_pkg::TIME_W'(r_intv);

    assign band_one = (d <= r_far) && (d > r_mid);
    assign band_two = (d <= r_mid) && (d >= r_near);
    assign beyond   = (d > r_far);
    assign in_close = (d <= r_close);
    assign near_hit = (d < r_near);

    // elapsed time wraps modulo 2^32
    assign dist_due  = (now - r_t_dist)  > intv_ext;
    assign touch_due = (now - r_t_touch) > intv_ext;
    assign stop_due  = (now - r_t_stop)  > intv_ext;

    // the divisor is nonzero whenever the quotient is used
    assign div_a = band_one ? (r_far - d) : (r_mid - d);
    assign div_b = band_one ? (r_far - r_mid) : (r_mid - r_near);

    pdi_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.start_div),
        .i_num   (div_a),
        .i_den   (div_b),
        .o_done  (div_done),
        .o_quot  (quot)
    );

    assign o_sts.div_done = div_done;

    always_comb begin
        n_run     = r_run;
        n_led1    = r_led1;
        n_led2    = r_led2;
        n_lvl1    = r_lvl1;
        n_lvl2    = r_lvl2;
        n_t_dist  = r_t_dist;
        n_t_touch = r_t_touch;
        n_t_stop  = r_t_stop;
        stop_st   = pdi_pkg::ST_NONE;
        force_st  = pdi_pkg::ST_NONE;
        rel       = 1'b0;
        dn        = 1'b0;
        tn        = 1'b0;
        cn        = 1'b0;
        if (!r_run) begin
            if (r_in.assist_request) begin
                n_run = 1'b1;
            end
        end else begin
            if (dist_due) begin
                dn       = 1'b1;
                n_t_dist = now;
            end
            if (r_in.stop_request) begin
                stop_st = in_close ? pdi_pkg::ST_ACCEPT : pdi_pkg::ST_REJECT;
            end
            if (!(r_in.stop_request && in_close)) begin
                if (band_one) begin
                    n_led1 = 1'b1;
                    n_led2 = 1'b0;
                    n_lvl1 = quot;
                    n_lvl2 = '0;
                end else if (band_two) begin
                    n_led1 = 1'b1;
                    n_led2 = 1'b1;
                    n_lvl1 = pdi_pkg::FULL_LEVEL;
                    n_lvl2 = (r_mid == r_near) ? pdi_pkg::FULL_LEVEL : quot;
                end else if (beyond) begin
                    n_led1 = 1'b0;
                    n_led2 = 1'b0;
                    n_lvl1 = '0;
                    n_lvl2 = '0;
                end else begin
                    n_led1 = 1'b1;
                    n_led2 = 1'b1;
                    n_lvl1 = pdi_pkg::FULL_LEVEL;
                    n_lvl2 = pdi_pkg::FULL_LEVEL;
                end
                if (r_in.touch_pressed && near_hit && touch_due) begin
                    tn        = 1'b1;
                    n_t_touch = now;
                end
                if (near_hit && stop_due) begin
                    cn       = 1'b1;
                    n_t_stop = now;
                end
            end else begin
                n_led1 = 1'b0;
                n_led2 = 1'b0;
                rel    = 1'b1;
                n_run  = 1'b0;
            end
            if (r_in.force_close) begin
                if (in_close) begin
                    force_st = pdi_pkg::ST_ACCEPT;
                    n_led1   = 1'b0;
                    n_led2   = 1'b0;
                    rel      = 1'b1;
                    n_run    = 1'b0;
                end else begin
                    force_st = pdi_pkg::ST_REJECT;
                end
            end
        end

        n_out.running         = n_run;
        n_out.led_one_on      = n_led1;
        n_out.led_two_on      = n_led2;
        n_out.level_one       = n_lvl1;
        n_out.level_two       = n_lvl2;
        n_out.stop_status     = stop_st;
        n_out.force_status    = force_st;
        n_out.release_assist  = rel;
        n_out.distance_notice = dn;
        n_out.touching_notice = tn;
        n_out.can_stop_notice = cn;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_far   <= pdi_pkg::RST_FAR;
            r_mid   <= pdi_pkg::RST_MIDDLE;
            r_near  <= pdi_pkg::RST_NEAR;
            r_close <= pdi_pkg::RST_CLOSE;
            r_intv  <= pdi_pkg::RST_INTV;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                pdi_pkg::CFG_FAR:    r_far   <= i_cfg_data[pdi_pkg::DIST_W-1:0];
                pdi_pkg::CFG_MIDDLE: r_mid   <= i_cfg_data[pdi_pkg::DIST_W-1:0];
                pdi_pkg::CFG_NEAR:   r_near  <= i_cfg_data[pdi_pkg::DIST_W-1:0];
                pdi_pkg::CFG_CLOSE:  r_close <= i_cfg_data[pdi_pkg::DIST_W-1:0];
                pdi_pkg::CFG_INTV:   r_intv  <= i_cfg_data[pdi_pkg::INTV_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run     <= 1'b0;
            r_led1    <= 1'b0;
            r_led2    <= 1'b0;
            r_lvl1    <= '0;
            r_lvl2    <= '0;
            r_t_dist  <= '0;
            r_t_touch <= '0;
            r_t_stop  <= '0;
        end else if (i_cmd.commit) begin
            r_run     <= n_run;
            r_led1    <= n_led1;
            r_led2    <= n_led2;
            r_lvl1    <= n_lvl1;
            r_lvl2    <= n_lvl2;
            r_t_dist  <= n_t_dist;
            r_t_touch <= n_t_touch;
            r_t_stop  <= n_t_stop;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_in <= i_in;
        end
        if (i_cmd.commit) begin
            r_out <= n_out;
        end
    end

    assign o_out = r_out;

endmodule

`default_nettype wire

// ===== hdl/parking_distance_indicator_core.sv =====
// Parking distance indicator, one request per tick of the assistant.
// Request channel: i_in_valid / o_in_stall with payload i_in (distance,
// time, assist/stop/force-close/touch flags). Result channel: o_out_valid /
// i_out_stall with payload o_out (run flag, LED enables and levels, stop and
// force-close status, release and the three notices). An item moves at a
// rising edge with valid high and stall low. Config writes use i_cfg_valid /
// o_cfg_ready (always ready), index i_cfg_index, data i_cfg_data; write only
// while no request is in flight.
// The result passes intake, launch of the serial divider for the LED level
// (one quotient bit per cycle over 8 bits) and commit; the next request is
// taken only once the result has been committed to the result register.
// A result waiting under i_out_stall holds; a new request is still taken and
// parks in the commit step until the result register frees up.
// Synchronous reset (i_rst_n low): paused, LEDs off, levels and notice times
// zero, limits back to 1000/500/100/300 mm and a 1000 ms notice interval.
// depends on pdi_pkg, pdi_ctrl, pdi_dp
`default_nettype none

module parking_distance_indicator_core (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_in_valid,
    output logic                             o_in_stall,
    input  pdi_pkg::t_in                     i_in,
    output logic                             o_out_valid,
    input  wire                              i_out_stall,
    output pdi_pkg::t_out                    o_out,
    input  wire                              i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire  [pdi_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire  [pdi_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    pdi_pkg::t_cmd cmd;
    pdi_pkg::t_sts sts;
    logic          cfg_we;

    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;

    pdi_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    pdi_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in        (i_in),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out       (o_out)
    );

endmodule

`default_nettype wire
